// ===== rtl/sspr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sspr_pkg;

    // input item kinds carried in tuser
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // result kinds carried in tuser
    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [23:0] TICK_MAX      = 24'hFFFFFF;
    localparam logic [23:0] TIMEOUT_RESET = 24'd200000;

    // frame hunt phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC1,
        PH_SYNC2,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    // controller state
    typedef enum logic [1:0] {
        CS_READY,
        CS_EMIT,
        CS_DRAIN_RD,
        CS_DRAIN_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic mem_rd;
        logic load_single;
        logic load_byte;
    } sspr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic single;
        logic drain;
        logic out_free;
        logic rd_last;
    } sspr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/servo_status_packet_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Servo-bus status reply receiver. A start request (tuser 2, expected ID in
// tdata[15:8]) arms the block and clears the tick count; byte requests (tuser 0,
// byte in tdata[7:0]) are hunted for two 0xFF sync bytes, ID, length and body,
// and tick requests (tuser 1) count towards timeout_ticks, written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// as the block does not enforce this. A good frame returns its body bytes
// without the checksum, error byte first, as a run marked by tlast, or one
// empty-reply result; a timeout returns one timeout result. A single result
// holds off new requests until it enters the output register; a good frame
// holds them off while each payload byte is read through the body store's
// registered read port and loaded out, plus any output stall. The body store
// needs no clearing pass after reset.
module servo_status_packet_receiver #(
    parameter int MAX_FRAME_LENGTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: timeout_ticks
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] reply_id
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_byte
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast
);
    import sspr_pkg::*;

    sspr_cmd_t cmd;
    sspr_sts_t sts;

    // controller
    sspr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    sspr_dp #(
        .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/sspr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire sspr_pkg::sspr_sts_t sts,
    output sspr_pkg::sspr_cmd_t      cmd
);
    import sspr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign s_tready = (state_reg == CS_READY);
    assign accept   = s_tvalid && s_tready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.step        = 1'b0;
        cmd.mem_rd      = 1'b0;
        cmd.load_single = 1'b0;
        cmd.load_byte   = 1'b0;
        case (state_reg)
            CS_READY:
            begin
                if (accept)
                begin
                    cmd.step = 1'b1;
                    if (sts.single)
                    begin
                        state_next = CS_EMIT;
                    end
                    else if (sts.drain)
                    begin
                        state_next = CS_DRAIN_RD;
                    end
                end
            end
            CS_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_single = 1'b1;
                    state_next      = CS_READY;
                end
            end
            CS_DRAIN_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = CS_DRAIN_OUT;
            end
            CS_DRAIN_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = sts.rd_last ? CS_READY : CS_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = CS_READY;
            end
        endcase
    end

    // checks
    a_single_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sts.single) |=> (state_reg == CS_EMIT))
        else $error("single result did not enter emit");

    a_drain_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sts.single && sts.drain) |=> (state_reg == CS_DRAIN_RD))
        else $error("good frame did not start drain");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_EMIT && sts.out_free) |=> (state_reg == CS_READY))
        else $error("emit did not return to ready");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_DRAIN_OUT && sts.out_free && sts.rd_last)
        |=> (state_reg == CS_READY))
        else $error("drain did not end on last byte");

endmodule

`default_nettype wire

// ===== rtl/sspr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspr_dp #(
    parameter int MAX_FRAME_LENGTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [23:0]         cfg_wr_data,
    input  wire logic [1:0]          s_tuser,
    input  wire logic [15:0]         s_tdata,
    input  wire sspr_pkg::sspr_cmd_t cmd,
    output sspr_pkg::sspr_sts_t      sts,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);
    import sspr_pkg::*;

    localparam int AW = (MAX_FRAME_LENGTH > 2) ? $clog2(MAX_FRAME_LENGTH) : 1;
    localparam int LW = $clog2(MAX_FRAME_LENGTH + 1);
    localparam logic [7:0] MAX_LEN8 = 8'(MAX_FRAME_LENGTH);

    logic [7:0] rx_byte;
    logic [7:0] reply_id;

    logic [23:0]   timeout_reg;
    phase_t        phase_reg, phase_next;
    logic [7:0]    wanted_id_reg, wanted_id_next;
    logic [7:0]    frame_id_reg, frame_id_next;
    logic [LW-1:0] frame_length_reg, frame_length_next;
    logic [AW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]    running_sum_reg, running_sum_next;
    logic [23:0]   tick_count_reg, tick_count_next;
    logic [23:0]   tick_inc;

    logic          evt_single;
    logic [1:0]    evt_status;
    logic          evt_drain;
    logic          mem_we;

    logic [1:0]    res_status_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_last;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;

    logic [7:0]    body_mem [MAX_FRAME_LENGTH];

    assign rx_byte  = s_tdata[7:0];
    assign reply_id = s_tdata[15:8];

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // frame hunt and tick logic for one request
    always_comb
    begin
        phase_next        = phase_reg;
        wanted_id_next    = wanted_id_reg;
        frame_id_next     = frame_id_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        tick_count_next   = tick_count_reg;
        tick_inc          = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                         : tick_count_reg + 24'd1;
        evt_single        = 1'b0;
        evt_status        = ST_TIMEOUT;
        evt_drain         = 1'b0;
        mem_we            = 1'b0;
        case (s_tuser)
            CMD_START:
            begin
                wanted_id_next    = reply_id;
                tick_count_next   = '0;
                byte_count_next   = '0;
                running_sum_next  = '0;
                frame_id_next     = '0;
                frame_length_next = '0;
                phase_next        = PH_SYNC1;
            end
            CMD_BYTE:
            begin
                case (phase_reg)
                    PH_SYNC1:
                    begin
                        if (rx_byte == SYNC_BYTE)
                        begin
                            phase_next = PH_SYNC2;
                        end
                    end
                    PH_SYNC2:
                    begin
                        phase_next = (rx_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
                    end
                    PH_ID:
                    begin
                        frame_id_next    = rx_byte;
                        running_sum_next = rx_byte;
                        phase_next       = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (rx_byte == 8'd0 || rx_byte > MAX_LEN8)
                        begin
                            phase_next = PH_SYNC1;
                        end
                        else
                        begin
                            frame_length_next = LW'(rx_byte);
                            running_sum_next  = running_sum_reg + rx_byte;
                            byte_count_next   = '0;
                            phase_next        = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        if ((LW'(byte_count_reg) + LW'(1)) < frame_length_reg)
                        begin
                            mem_we           = 1'b1;
                            running_sum_next = running_sum_reg + rx_byte;
                            byte_count_next  = byte_count_reg + AW'(1);
                        end
                        else if (rx_byte == ~running_sum_reg
                                 && frame_id_reg == wanted_id_reg)
                        begin
                            phase_next = PH_IDLE;
                            if (byte_count_reg == '0)
                            begin
                                evt_single = 1'b1;
                                evt_status = ST_EMPTY;
                            end
                            else
                            begin
                                evt_drain = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SYNC1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= timeout_reg)
                    begin
                        phase_next = PH_IDLE;
                        evt_single = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // protocol state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            wanted_id_reg    <= '0;
            frame_id_reg     <= '0;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
            tick_count_reg   <= '0;
        end
        else if (cmd.step)
        begin
            phase_reg        <= phase_next;
            wanted_id_reg    <= wanted_id_next;
            frame_id_reg     <= frame_id_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            tick_count_reg   <= tick_count_next;
        end
    end

    // pending single result and drain index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_status_reg <= ST_TIMEOUT;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (cmd.step && evt_single)
            begin
                res_status_reg <= evt_status;
            end
            if (cmd.step && evt_drain)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.load_byte)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    assign rd_last = (rd_idx_reg == byte_count_reg - AW'(1));

    // body store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.step && mem_we)
        begin
            body_mem[byte_count_reg] <= rx_byte;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= body_mem[rd_idx_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_single || cmd.load_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_single)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            out_status_reg <= ST_PAYLOAD;
            out_data_reg   <= rd_data_reg;
            out_last_reg   <= rd_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // status to controller
    assign sts.single   = evt_single;
    assign sts.drain    = evt_drain;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.rd_last  = rd_last;

endmodule

`default_nettype wire
